@@ rtl/core/pwa_pkg.sv @@
// Shared types and constants for the pulse width averager.
`default_nettype none

package pwa_pkg;

   // timer capture width used for edge arithmetic
   localparam int TIME_WIDTH  = 16;
   localparam int CMP_WIDTH   = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

   localparam int MODE_WIDTH  = 2;
   localparam int STAMP_WIDTH = 16;
   localparam int VALUE_WIDTH = 16;
   localparam int TOTAL_WIDTH = 32;
   localparam int COUNT_WIDTH = 16;

   // input mode codes
   localparam logic [MODE_WIDTH-1:0] MODE_RISE    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_FALL    = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_AVERAGE = 2'd2;

   localparam logic [VALUE_WIDTH-1:0] INVALID_AVERAGE = 16'h8000;
   localparam logic [VALUE_WIDTH-1:0] MAX_GAP_RESET   = 16'd4000;

   // register file: one word, max_gap at word 0
   localparam int                     CSR_ADDR_WIDTH = 3;
   localparam int                     CSR_DATA_WIDTH = 32;
   localparam logic                   CSR_WORD_MAX_GAP = 1'b0;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // restoring divider: one quotient bit per cycle, may stall
   localparam int DIV_STEPS  = 16;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_RISE,
      OP_FALL,
      OP_AVERAGE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [TIME_WIDTH-1:0]  stamp;
   } entry_type;

   typedef enum logic {
      BE_IDLE,
      BE_DIVIDE
   } back_state_type;

   // back end control decisions for one cycle
   typedef struct packed {
      logic pop;
      logic div_start;
      logic div_advance;
      logic div_finish;
      logic load_out;
   } back_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/pwa_req_if.sv @@
// Input channel: timestamped edge or average request.
`default_nettype none

interface pwa_req_if;
   import pwa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MODE_WIDTH-1:0]   mode;
   logic [STAMP_WIDTH-1:0]  event_time;

   modport source (output valid, output mode, output event_time, input ready);
   modport sink   (input valid, input mode, input event_time, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pwa_rsp_if.sv @@
// Result channel: average, gap, sample count and alarm.
`default_nettype none

interface pwa_rsp_if;
   import pwa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [VALUE_WIDTH-1:0]  range_value;
   logic [VALUE_WIDTH-1:0]  gap_value;
   logic [COUNT_WIDTH-1:0]  sample_count;
   logic                    gap_alarm;

   modport source (output valid, output range_value, output gap_value,
                   output sample_count, output gap_alarm, input ready);
   modport sink   (input valid, input range_value, input gap_value,
                   input sample_count, input gap_alarm, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pwa_front.sv @@
// Front end: accepts input items and classifies them into queue entries.
`default_nettype none

module pwa_front (
   pwa_req_if.sink              req_ch,
   input  wire logic            q_full,
   output logic                 q_push,
   output pwa_pkg::entry_type   q_entry
);
   import pwa_pkg::*;

   op_type op;

   always_comb begin
      case (req_ch.mode)
         MODE_RISE:    op = OP_RISE;
         MODE_FALL:    op = OP_FALL;
         MODE_AVERAGE: op = OP_AVERAGE;
         default:      op = OP_NONE;
      endcase
   end

   assign req_ch.ready  = !q_full;
   assign q_push        = req_ch.valid && !q_full;
   assign q_entry.op    = op;
   assign q_entry.stamp = TIME_WIDTH'(req_ch.event_time);

endmodule

`default_nettype wire

@@ rtl/core/pwa_queue.sv @@
// Short FIFO of classified items between front and back.
`default_nettype none

module pwa_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pwa_pkg::entry_type  push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output pwa_pkg::entry_type       head_entry
);
   import pwa_pkg::*;

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff,  count_in;

   function automatic logic [QPTR_WIDTH-1:0] next_ptr(input logic [QPTR_WIDTH-1:0] p);
      if (p == QPTR_WIDTH'(QUEUE_DEPTH - 1))
         return '0;
      return p + 1'b1;
   endfunction

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

@@ rtl/core/pwa_back.sv @@
// Back end: edge measurement, sums, serial divide and result register.
`default_nettype none

module pwa_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [pwa_pkg::VALUE_WIDTH-1:0] max_gap,
   input  wire logic                       q_valid,
   input  wire pwa_pkg::entry_type         q_head,
   output logic                            q_pop,
   pwa_rsp_if.source                       rsp_ch
);
   import pwa_pkg::*;

   back_state_type            state_ff, state_in;
   back_ctrl_type             ctrl;

   logic [TIME_WIDTH-1:0]     rise_time_ff, rise_time_in;
   logic [TIME_WIDTH-1:0]     fall_time_ff, fall_time_in;
   logic [TIME_WIDTH-1:0]     gap_ff,       gap_in;
   logic [TOTAL_WIDTH-1:0]    live_total_ff, live_total_in;
   logic [COUNT_WIDTH-1:0]    live_count_ff, live_count_in;
   logic [TOTAL_WIDTH-1:0]    snap_total_ff, snap_total_in;
   logic [COUNT_WIDTH-1:0]    snap_count_ff, snap_count_in;
   logic [VALUE_WIDTH-1:0]    average_ff,   average_in;
   logic                      pending_ff,   pending_in;
   logic                      alarm_ff,     alarm_in;

   logic [COUNT_WIDTH-1:0]    rem_ff,  rem_in;
   logic [VALUE_WIDTH-1:0]    quot_ff, quot_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]    rsp_range_ff, rsp_gap_ff;
   logic [COUNT_WIDTH-1:0]    rsp_count_ff;
   logic                      rsp_alarm_ff;

   logic                      out_free;
   logic                      avg_invalid;
   logic                      last_step;
   logic [COUNT_WIDTH:0]      trial;
   logic [COUNT_WIDTH:0]      trial_diff;
   logic                      qbit;
   logic [TIME_WIDTH-1:0]     pulse_width;
   logic [TOTAL_WIDTH-1:0]    base_total;
   logic [COUNT_WIDTH-1:0]    base_count;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign avg_invalid = (snap_count_ff == '0) ||
                        (snap_total_ff[TOTAL_WIDTH-1 -: COUNT_WIDTH] >= snap_count_ff);
   assign last_step   = (step_ff == STEP_WIDTH'(DIV_STEPS - 1));

   // one restoring divide step
   assign trial      = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign trial_diff = trial - {1'b0, snap_count_ff};
   assign qbit       = (trial >= {1'b0, snap_count_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE: begin
            if (q_valid && out_free && q_head.op == OP_AVERAGE && !avg_invalid)
               state_in = BE_DIVIDE;
         end
         BE_DIVIDE: begin
            if (last_step && out_free)
               state_in = BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         BE_IDLE: begin
            ctrl.pop       = q_valid && out_free;
            ctrl.div_start = ctrl.pop && q_head.op == OP_AVERAGE && !avg_invalid;
            ctrl.load_out  = ctrl.pop && !ctrl.div_start;
         end
         BE_DIVIDE: begin
            ctrl.div_advance = !last_step || out_free;
            ctrl.div_finish  = last_step && out_free;
            ctrl.load_out    = ctrl.div_finish;
         end
         default: ctrl = '0;
      endcase
   end

   assign q_pop = ctrl.pop;

   // datapath next values
   always_comb begin
      rise_time_in  = rise_time_ff;
      fall_time_in  = fall_time_ff;
      gap_in        = gap_ff;
      live_total_in = live_total_ff;
      live_count_in = live_count_ff;
      snap_total_in = snap_total_ff;
      snap_count_in = snap_count_ff;
      average_in    = average_ff;
      pending_in    = pending_ff;
      alarm_in      = alarm_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      pulse_width   = q_head.stamp - rise_time_ff;
      base_total    = live_total_ff;
      base_count    = live_count_ff;

      if (ctrl.pop && (q_head.op == OP_RISE || q_head.op == OP_FALL)) begin
         // an armed snapshot is taken ahead of the edge
         if (pending_ff) begin
            snap_total_in = live_total_ff;
            snap_count_in = live_count_ff;
            base_total    = '0;
            base_count    = '0;
            pending_in    = 1'b0;
         end
         live_total_in = base_total;
         live_count_in = base_count;
         if (q_head.op == OP_RISE) begin
            rise_time_in = q_head.stamp;
            gap_in       = q_head.stamp - fall_time_ff;
         end else begin
            fall_time_in = q_head.stamp;
            if (CMP_WIDTH'(gap_ff) > CMP_WIDTH'(max_gap)) begin
               alarm_in = 1'b1;
            end else begin
               alarm_in      = 1'b0;
               live_count_in = base_count + 1'b1;
               live_total_in = base_total + TOTAL_WIDTH'(pulse_width);
            end
         end
      end

      if (ctrl.pop && q_head.op == OP_AVERAGE) begin
         if (avg_invalid) begin
            average_in = INVALID_AVERAGE;
            pending_in = 1'b1;
         end else begin
            rem_in  = snap_total_ff[TOTAL_WIDTH-1 -: COUNT_WIDTH];
            quot_in = snap_total_ff[VALUE_WIDTH-1:0];
            step_in = '0;
         end
      end

      if (ctrl.div_advance) begin
         rem_in  = qbit ? trial_diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
         quot_in = {quot_ff[VALUE_WIDTH-2:0], qbit};
         step_in = step_ff + 1'b1;
      end

      if (ctrl.div_finish) begin
         average_in = {quot_ff[VALUE_WIDTH-2:0], qbit};
         pending_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BE_IDLE;
         rise_time_ff  <= '0;
         fall_time_ff  <= '0;
         gap_ff        <= '0;
         live_total_ff <= '0;
         live_count_ff <= '0;
         snap_total_ff <= '0;
         snap_count_ff <= '0;
         average_ff    <= '0;
         pending_ff    <= 1'b0;
         alarm_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rise_time_ff  <= rise_time_in;
         fall_time_ff  <= fall_time_in;
         gap_ff        <= gap_in;
         live_total_ff <= live_total_in;
         live_count_ff <= live_count_in;
         snap_total_ff <= snap_total_in;
         snap_count_ff <= snap_count_in;
         average_ff    <= average_in;
         pending_ff    <= pending_in;
         alarm_ff      <= alarm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // divider and result payload
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      if (ctrl.load_out) begin
         rsp_range_ff <= average_in;
         rsp_gap_ff   <= VALUE_WIDTH'(gap_in);
         rsp_count_ff <= snap_count_in;
         rsp_alarm_ff <= alarm_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.range_value  = rsp_range_ff;
   assign rsp_ch.gap_value    = rsp_gap_ff;
   assign rsp_ch.sample_count = rsp_count_ff;
   assign rsp_ch.gap_alarm    = rsp_alarm_ff;

endmodule

`default_nettype wire

@@ rtl/core/pulse_width_averager.sv @@
// Top level of the pulse width averager: channels, CSR port, front, queue, back.
//
// Usage:
//  - req_ch carries one item per handshake: mode 0 rising edge, 1 falling edge,
//    2 average request (3 no-op, still answered), event_time the timer capture.
//  - Every accepted item yields exactly one item on rsp_ch: the averaged width
//    (32768 when empty or out of range), latest gap, snapshot count and alarm.
//  - max_gap is written through the APB-style csr_ port at byte address 0;
//    change it only while the block is idle.
//  - Path: an edge passes the queue and is loaded into the result register. An
//    average request runs the 16-step serial divider, one quotient bit per
//    cycle, the last bit waiting for a free result register; empty or
//    overflowing averages take the edge path. Edges flow one per cycle while the
//    receiver takes results; an average holds the back end while it divides.
//  - A two-entry queue keeps req_ch ready while a result waits on a stalled
//    receiver; req_ch drops ready only when the queue is full.
//  - Reset is synchronous: sums, times, snapshot, queue and result valid flag
//    clear, and max_gap returns to 4000.
`default_nettype none

module pulse_width_averager (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pwa_req_if.sink                                  req_ch,
   pwa_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pwa_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [pwa_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [pwa_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                     csr_pready
);
   import pwa_pkg::*;

   logic [VALUE_WIDTH-1:0]  max_gap_ff, max_gap_in;
   logic                    csr_write;
   logic                    csr_hit;

   logic                    q_push;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_valid;
   entry_type               q_entry;
   entry_type               q_head;

   // CSR: single word, max_gap in the low half
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_WORD_MAX_GAP);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_gap_in = max_gap_ff;
      if (csr_write && csr_hit)
         max_gap_in = csr_pwdata[VALUE_WIDTH-1:0];
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit)
         csr_prdata = CSR_DATA_WIDTH'(max_gap_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= MAX_GAP_RESET;
      end else begin
         max_gap_ff <= max_gap_in;
      end
   end

   // front end: accept and classify
   pwa_front u_front (
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   // decoupling queue
   pwa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   // back end: measure, accumulate, divide, respond
   pwa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .max_gap (max_gap_ff),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire
